### rtl/gbn_pkg.sv
// ----------------------------------------------------------------------------
// Go-back-N sender package
// Shared sizes, operation and result codes, and stream packing layout.
// ----------------------------------------------------------------------------
package gbn_pkg;

    // Ring of send slots and the cap on results caused by one transaction.
    localparam int WINDOW  = 64;
    localparam int MAX_OUT = 64;
    localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int WIN_CW  = $clog2(WINDOW + 1);
    localparam int CNT_W   = $clog2(MAX_OUT + 1);

    // Field widths.
    localparam int SEQ_W    = 31;
    localparam int TICK_W   = 32;
    localparam int RESENT_W = 32;
    localparam int RTT_W    = 63;
    localparam int CFG_W    = 32;

    // Configuration register indexes and reset values.
    localparam logic REG_TOTAL   = 1'b0;
    localparam logic REG_TIMEOUT = 1'b1;
    localparam logic [SEQ_W-1:0]  TOTAL_RESET   = 31'd1000000;
    localparam logic [TICK_W-1:0] TIMEOUT_RESET = 32'd100000;

    // Input opcodes.
    localparam logic [1:0] OP_SEND = 2'd0;
    localparam logic [1:0] OP_ACK  = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;
    localparam logic [1:0] OP_NOP  = 2'd3;

    // Result kinds.
    localparam logic [2:0] KIND_SEND    = 3'd0;
    localparam logic [2:0] KIND_RESEND  = 3'd1;
    localparam logic [2:0] KIND_ACK     = 3'd2;
    localparam logic [2:0] KIND_NO_SEND = 3'd3;
    localparam logic [2:0] KIND_NO_TICK = 3'd4;

    // Stream widths.
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 192;
    localparam int M_TUSER_W = 3;

endpackage

### rtl/go_back_n_sender_core.sv
// ----------------------------------------------------------------------------
// Go-back-N sender core
// Sliding-window sender: issues new sequence numbers, handles cumulative acks
// and resends the whole outstanding window on timeout.
// ----------------------------------------------------------------------------
// Usage: one transaction on the slave stream carries an opcode in tuser (send
// opportunity, cumulative ack, tick, no-op) and an ack number in tdata. Each one
// yields one result or more on the master stream; tlast marks the final one.
// Send times live in a 64-entry memory with one read and one write port.
// A send opportunity gives one new send per cycle while the master stream
// accepts, up to 64 in a burst. An ack issues one memory read per slot, with
// the age summed in the cycle after, as the read data returns. A tick with
// nothing outstanding yields a no-action result; otherwise the base slot's
// send time is read, and when that slot has timed out the resend walk
// rewrites one send time per cycle while the master stream accepts.
// A new transaction is taken only when the previous one has issued its last
// result; that result may still sit in the output register.
// When the master stream stalls, the walk holds and no result is lost.
// Reset (synchronous, active low) clears the window, time and counters and
// loads the default total and timeout; the memory needs no clearing since
// only slots that were sent are ever read.
// Configuration writes are taken at any time and must come while idle.
// ----------------------------------------------------------------------------
module go_back_n_sender_core
    import gbn_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // slave stream: tdata = ack_number[30:0]; tuser = opcode[1:0]
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [S_TDATA_W-1:0] i_s_axis_tdata,
    input  logic [S_TUSER_W-1:0] i_s_axis_tuser,
    // master stream: tdata = seq_number[30:0], acked_total[61:31],
    // sent_total[92:62], resent_total[124:93], rtt_sum[187:125],
    // all_done[188]; tuser = result_kind[2:0]
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [M_TDATA_W-1:0] o_m_axis_tdata,
    output logic [M_TUSER_W-1:0] o_m_axis_tuser,
    output logic                 o_m_axis_tlast,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_addr,
    input  logic [CFG_W-1:0]     i_cfg_wdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEND,
        S_ACK,
        S_TICK_CHK,
        S_RESEND,
        S_NOACT
    } t_state;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        slot_inc = (s == SLOT_W'(WINDOW - 1)) ? '0 : s + 1'b1;
    endfunction

    t_state r_state, n_state;

    logic [SEQ_W-1:0]    r_total, r_base, n_base, r_next, n_next;
    logic [TICK_W-1:0]   r_timeout, r_tick, n_tick;
    logic [SLOT_W-1:0]   r_base_slot, n_base_slot, r_next_slot, n_next_slot;
    logic [SLOT_W-1:0]   r_q_slot, n_q_slot;
    logic [SEQ_W-1:0]    r_q, n_q;
    logic [WIN_CW-1:0]   r_left, n_left;
    logic [CNT_W-1:0]    r_n, n_n;
    logic                r_rd_pend, n_rd_pend;
    logic [SEQ_W-1:0]    r_acked, n_acked, r_sent, n_sent;
    logic [RESENT_W-1:0] r_resent, n_resent;
    logic [RTT_W-1:0]    r_rtt, n_rtt;

    logic                r_out_valid, n_out_valid;
    logic [2:0]          r_out_kind;
    logic [SEQ_W-1:0]    r_out_seq, r_out_acked, r_out_sent;
    logic                r_out_last, r_out_done;
    logic [RESENT_W-1:0] r_out_resent;
    logic [RTT_W-1:0]    r_out_rtt;

    logic                emit, e_last;
    logic [2:0]          e_kind;
    logic [SEQ_W-1:0]    e_seq;

    logic                ram_we, ram_re;
    logic [SLOT_W-1:0]   ram_waddr, ram_raddr;
    logic [TICK_W-1:0]   ram_wdata, ram_rdata;

    logic                out_free;
    logic [SEQ_W-1:0]    ack_num, next_m1, ack_top, ack_span;
    logic [WIN_CW-1:0]   ack_left;
    logic [31:0]         win_used;
    logic                send_ok, send_more, resend_more;
    logic [TICK_W-1:0]   age;
    logic [RTT_W:0]      rtt_sum;

    gbn_ram #(
        .WIDTH (TICK_W),
        .DEPTH (WINDOW)
    ) u_sent_time (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign out_free = !r_out_valid || i_m_axis_tready;
    assign ack_num  = i_s_axis_tdata[SEQ_W-1:0];
    assign next_m1  = r_next - 1'b1;
    assign ack_top  = (ack_num > next_m1) ? next_m1 : ack_num;
    assign ack_span = ack_top - r_base;
    // An ack below the base or before any send covers no slot.
    assign ack_left = (r_next != '0 && ack_top >= r_base) ?
                      WIN_CW'(ack_span + 1'b1) : '0;

    assign win_used    = {1'b0, r_next} - {1'b0, r_base};
    assign send_ok     = (r_n < CNT_W'(MAX_OUT)) && (r_next < r_total) &&
                         (win_used < 32'(WINDOW));
    assign send_more   = (r_n < CNT_W'(MAX_OUT - 1)) &&
                         (({1'b0, r_next} + 32'd1) < {1'b0, r_total}) &&
                         (win_used < 32'(WINDOW - 1));
    assign resend_more = ((r_q + 1'b1) != r_next) && (r_n < CNT_W'(MAX_OUT - 1));

    assign age     = r_tick - ram_rdata;
    assign rtt_sum = {1'b0, r_rtt} + (RTT_W + 1)'(age);

    always_comb begin
        n_state     = r_state;
        n_base      = r_base;
        n_base_slot = r_base_slot;
        n_next      = r_next;
        n_next_slot = r_next_slot;
        n_tick      = r_tick;
        n_q         = r_q;
        n_q_slot    = r_q_slot;
        n_left      = r_left;
        n_n         = r_n;
        n_rd_pend   = 1'b0;
        n_acked     = r_acked;
        n_sent      = r_sent;
        n_resent    = r_resent;
        n_rtt       = r_rtt;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        emit        = 1'b0;
        e_kind      = KIND_NO_TICK;
        e_seq       = '0;
        e_last      = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = r_next_slot;
        ram_wdata   = r_tick;
        ram_re      = 1'b0;
        ram_raddr   = r_base_slot;

        unique case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    unique case (i_s_axis_tuser)
                        OP_SEND: begin
                            n_n     = '0;
                            n_state = S_SEND;
                        end
                        OP_ACK: begin
                            n_q_slot = r_base_slot;
                            n_left   = ack_left;
                            n_state  = S_ACK;
                        end
                        OP_TICK: begin
                            n_tick = r_tick + 1'b1;
                            // Fetch the base slot's send time for the age check.
                            if (r_base != r_next) begin
                                ram_re    = 1'b1;
                                ram_raddr = r_base_slot;
                                n_state   = S_TICK_CHK;
                            end else begin
                                n_state = S_NOACT;
                            end
                        end
                        OP_NOP: begin
                            n_state = S_NOACT;
                        end
                    endcase
                end
            end

            S_SEND: begin
                if (out_free) begin
                    emit   = 1'b1;
                    e_last = 1'b1;
                    if (send_ok) begin
                        ram_we      = 1'b1;
                        ram_waddr   = r_next_slot;
                        n_sent      = (r_sent != '1) ? r_sent + 1'b1 : r_sent;
                        n_next      = r_next + 1'b1;
                        n_next_slot = slot_inc(r_next_slot);
                        n_n         = r_n + 1'b1;
                        e_kind      = KIND_SEND;
                        e_seq       = r_next;
                        e_last      = !send_more;
                    end else begin
                        e_kind = KIND_NO_SEND;
                    end
                    if (e_last) begin
                        n_state = S_IDLE;
                    end
                end
            end

            S_ACK: begin
                // Reads go out one per cycle; each returning send time is
                // summed the cycle after and the base slides over its slot.
                if (r_left != '0) begin
                    ram_re    = 1'b1;
                    ram_raddr = r_q_slot;
                    n_q_slot  = slot_inc(r_q_slot);
                    n_left    = r_left - 1'b1;
                    n_rd_pend = 1'b1;
                end
                if (r_rd_pend) begin
                    n_rtt       = rtt_sum[RTT_W] ? '1 : rtt_sum[RTT_W-1:0];
                    n_acked     = (r_acked != '1) ? r_acked + 1'b1 : r_acked;
                    n_base      = r_base + 1'b1;
                    n_base_slot = slot_inc(r_base_slot);
                end
                if (r_left == '0 && !r_rd_pend && out_free) begin
                    emit    = 1'b1;
                    e_kind  = KIND_ACK;
                    e_last  = 1'b1;
                    n_state = S_IDLE;
                end
            end

            S_TICK_CHK: begin
                if (age > r_timeout) begin
                    n_q      = r_base;
                    n_q_slot = r_base_slot;
                    n_n      = '0;
                    n_state  = S_RESEND;
                end else begin
                    n_state = S_NOACT;
                end
            end

            S_RESEND: begin
                if (out_free) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_q_slot;
                    n_resent  = (r_resent != '1) ? r_resent + 1'b1 : r_resent;
                    n_q       = r_q + 1'b1;
                    n_q_slot  = slot_inc(r_q_slot);
                    n_n       = r_n + 1'b1;
                    emit      = 1'b1;
                    e_kind    = KIND_RESEND;
                    e_seq     = r_q;
                    e_last    = !resend_more;
                    if (!resend_more) begin
                        n_state = S_IDLE;
                    end
                end
            end

            S_NOACT: begin
                if (out_free) begin
                    emit    = 1'b1;
                    e_kind  = KIND_NO_TICK;
                    e_last  = 1'b1;
                    n_state = S_IDLE;
                end
            end
        endcase

        if (emit) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_total     <= TOTAL_RESET;
            r_timeout   <= TIMEOUT_RESET;
            r_base      <= '0;
            r_base_slot <= '0;
            r_next      <= '0;
            r_next_slot <= '0;
            r_tick      <= '0;
            r_left      <= '0;
            r_n         <= '0;
            r_rd_pend   <= 1'b0;
            r_acked     <= '0;
            r_sent      <= '0;
            r_resent    <= '0;
            r_rtt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_base      <= n_base;
            r_base_slot <= n_base_slot;
            r_next      <= n_next;
            r_next_slot <= n_next_slot;
            r_tick      <= n_tick;
            r_left      <= n_left;
            r_n         <= n_n;
            r_rd_pend   <= n_rd_pend;
            r_acked     <= n_acked;
            r_sent      <= n_sent;
            r_resent    <= n_resent;
            r_rtt       <= n_rtt;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    REG_TOTAL:   r_total   <= i_cfg_wdata[SEQ_W-1:0];
                    REG_TIMEOUT: r_timeout <= i_cfg_wdata[TICK_W-1:0];
                endcase
            end
        end
        r_q      <= n_q;
        r_q_slot <= n_q_slot;
        if (emit) begin
            r_out_kind   <= e_kind;
            r_out_seq    <= e_seq;
            r_out_last   <= e_last;
            r_out_acked  <= n_acked;
            r_out_sent   <= n_sent;
            r_out_resent <= n_resent;
            r_out_rtt    <= n_rtt;
            r_out_done   <= (n_acked >= r_total);
        end
    end

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tlast  = r_out_last;
    assign o_m_axis_tdata  = {3'b000, r_out_done, r_out_rtt, r_out_resent,
                              r_out_sent, r_out_acked, r_out_seq};

`ifndef NO_ASSERTIONS
    a_ram_port_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("send-time memory read and written in one cycle");

    a_window_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_base <= r_next) && (win_used <= 32'(WINDOW)))
        else $error("outstanding span exceeds the window");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("new transaction taken while one is in progress");

    a_read_in_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |-> (r_state == S_ACK))
        else $error("ack read data returned outside the ack walk");
`endif

endmodule

### rtl/gbn_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module gbn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
